/* sv/hpng_pkg.sv */
// Shared types, constants and rounding and saturation helpers for the stereo noise gate.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package hpng_pkg;

	localparam int SAMPLE_W = 16;
	localparam int HP_W     = 24;
	localparam int FRAC     = 16;
	localparam int GAIN_W   = FRAC + 1;
	localparam int THR_W    = 14;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = 45;
	localparam int RND_W    = PROD_W - FRAC;
	localparam int ACC_W    = 35;
	localparam int DIV_STEPS = FRAC;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [GAIN_W-1:0] UNITY     = GAIN_W'(1 << FRAC);
	localparam logic [THR_W-1:0]  THR_MAX   = THR_W'(1 << (SAMPLE_W - 3));
	localparam logic [COEF_W-1:0] SMOOTH_LO = COEF_W'(((1 << FRAC) * 5 + 50) / 100);
	localparam logic [COEF_W-1:0] SMOOTH_HI = COEF_W'(((1 << FRAC) * 95 + 50) / 100);
	localparam logic [COEF_W-1:0] HP_COEF_RST = COEF_W'(44250);

	localparam logic signed [RND_W-1:0] SMP_HI_R = RND_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [RND_W-1:0] SMP_LO_R = RND_W'(-(1 << (SAMPLE_W - 1)));
	localparam logic signed [RND_W-1:0] HP_HI_R  = RND_W'((1 << (HP_W - 1)) - 1);
	localparam logic signed [RND_W-1:0] HP_LO_R  = RND_W'(-(1 << (HP_W - 1)));

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS   = 3'd4;

	typedef enum logic [2:0] {
		LN_NOP,
		LN_GAIN_MUL,
		LN_GAIN_SAT,
		LN_HP_MUL,
		LN_HP_SAT,
		LN_OUT_MUL,
		LN_OUT_SAT
	} lane_op_t;

	typedef enum logic [2:0] {
		MG_NOP,
		MG_NOISE,
		MG_DIV,
		MG_TGT_MUL,
		MG_TGT,
		MG_SM_A,
		MG_SM_B,
		MG_SM_END
	} merge_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GMUL,
		ST_GSAT,
		ST_HMUL,
		ST_HSAT,
		ST_NOISE,
		ST_DIV,
		ST_TMUL,
		ST_TGT,
		ST_SMA,
		ST_SMB,
		ST_SME,
		ST_OMUL,
		ST_OSAT
	} state_t;

	// Round half up and drop the fraction bits of a signed product.
	function automatic logic signed [RND_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(1 << (FRAC - 1));
		return t[PROD_W-1:FRAC];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [RND_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SMP_HI_R) begin
			r = SMP_HI_R[SAMPLE_W-1:0];
		end else if (v < SMP_LO_R) begin
			r = SMP_LO_R[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [HP_W-1:0] sat_hp(input logic signed [RND_W-1:0] v);
		logic signed [HP_W-1:0] r;
		if (v > HP_HI_R) begin
			r = HP_HI_R[HP_W-1:0];
		end else if (v < HP_LO_R) begin
			r = HP_LO_R[HP_W-1:0];
		end else begin
			r = v[HP_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/hpng_if.sv */
// Valid/ready channel interfaces for sample pairs and gated results.
// Depends on hpng_pkg for the sample width.
`default_nettype none
interface hpng_in_if import hpng_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       block_end;

	modport source(output valid, left_sample, right_sample, block_end, input ready);
	modport sink(input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface hpng_out_if import hpng_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       block_end_out;

	modport source(output valid, left_out, right_out, block_end_out, input ready);
	modport sink(input valid, left_out, right_out, block_end_out, output ready);
endinterface
`default_nettype wire

/* sv/stereo_hf_noise_gate.sv */
// Stereo high-frequency noise gate. A request is accepted only in the idle state;
// its result passes through 12 steps plus the 16-step serial divider of the merging
// stage, and no new pair is taken until the block is idle again, which waits while a
// previous result is not yet taken. The output register lets the next pair start
// while a result waits. Reset restores the default registers, clears filter state and
// sets the smoothed gain to unity.
`default_nettype none
module stereo_hf_noise_gate import hpng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hpng_in_if.sink               sample_ch,
	hpng_out_if.source            result_ch,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [GAIN_W-1:0] input_gain_q;
	logic [THR_W-1:0]  threshold_q;
	logic [GAIN_W-1:0] reduction_q;
	logic [COEF_W-1:0] smoothing_q;
	logic [COEF_W-1:0] highpass_q;

	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       be_q;
	logic                       be_out_q;
	logic                       res_valid_q;

	state_t    state_q;
	state_t    state_d;
	lane_op_t  lane_op;
	merge_op_t merge_op;

	logic [GAIN_W-1:0] gain_c;
	logic [THR_W-1:0]  thr_c;
	logic [GAIN_W-1:0] red_c;
	logic [COEF_W-1:0] smooth_c;
	logic [GAIN_W-1:0] level;
	logic              div_done;
	logic              slot_free;
	logic              accept;
	logic signed [HP_W-1:0] hp_l;
	logic signed [HP_W-1:0] hp_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_gain_q <= UNITY;
			threshold_q  <= '0;
			reduction_q  <= '0;
			smoothing_q  <= SMOOTH_LO;
			highpass_q   <= HP_COEF_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_INPUT_GAIN: input_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_THRESHOLD:  threshold_q  <= cfg_data[THR_W-1:0];
				CFG_REDUCTION:  reduction_q  <= cfg_data[GAIN_W-1:0];
				CFG_SMOOTHING:  smoothing_q  <= cfg_data[COEF_W-1:0];
				CFG_HIGHPASS:   highpass_q   <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign gain_c   = (input_gain_q > UNITY) ? UNITY : input_gain_q;
	assign thr_c    = (threshold_q > THR_MAX) ? THR_MAX : threshold_q;
	assign red_c    = (reduction_q > UNITY) ? UNITY : reduction_q;
	assign smooth_c = (smoothing_q < SMOOTH_LO) ? SMOOTH_LO :
		(smoothing_q > SMOOTH_HI) ? SMOOTH_HI : smoothing_q;

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign slot_free       = !res_valid_q || result_ch.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= sample_ch.left_sample;
			right_q <= sample_ch.right_sample;
			be_q    <= sample_ch.block_end;
		end
		if (state_q == ST_OSAT && slot_free) begin
			be_out_q <= be_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OSAT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		lane_op  = LN_NOP;
		merge_op = MG_NOP;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_GMUL;
			ST_GMUL: begin
				lane_op = LN_GAIN_MUL;
				state_d = ST_GSAT;
			end
			ST_GSAT: begin
				lane_op = LN_GAIN_SAT;
				state_d = ST_HMUL;
			end
			ST_HMUL: begin
				lane_op = LN_HP_MUL;
				state_d = ST_HSAT;
			end
			ST_HSAT: begin
				lane_op = LN_HP_SAT;
				state_d = ST_NOISE;
			end
			ST_NOISE: begin
				merge_op = MG_NOISE;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				merge_op = MG_DIV;
				if (div_done) state_d = ST_TMUL;
			end
			ST_TMUL: begin
				merge_op = MG_TGT_MUL;
				state_d  = ST_TGT;
			end
			ST_TGT: begin
				merge_op = MG_TGT;
				state_d  = ST_SMA;
			end
			ST_SMA: begin
				merge_op = MG_SM_A;
				state_d  = ST_SMB;
			end
			ST_SMB: begin
				merge_op = MG_SM_B;
				state_d  = ST_SME;
			end
			ST_SME: begin
				merge_op = MG_SM_END;
				state_d  = ST_OMUL;
			end
			ST_OMUL: begin
				lane_op = LN_OUT_MUL;
				state_d = ST_OSAT;
			end
			ST_OSAT: begin
				// The result register is written only once the previous result is gone.
				if (slot_free) begin
					lane_op = LN_OUT_SAT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	hpng_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lane_op),
		.sample (left_q),
		.gain   (gain_c),
		.hpc    (highpass_q),
		.level  (level),
		.hp     (hp_l),
		.result (result_ch.left_out)
	);

	hpng_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lane_op),
		.sample (right_q),
		.gain   (gain_c),
		.hpc    (highpass_q),
		.level  (level),
		.hp     (hp_r),
		.result (result_ch.right_out)
	);

	hpng_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (merge_op),
		.hp_l     (hp_l),
		.hp_r     (hp_r),
		.thr      (thr_c),
		.red      (red_c),
		.smooth   (smooth_c),
		.gain     (level),
		.div_done (div_done)
	);

	assign result_ch.valid         = res_valid_q;
	assign result_ch.block_end_out = be_out_q;

endmodule
`default_nettype wire

/* sv/hpng_lane.sv */
// One channel lane: input gain, one-pole high-pass state and output scaling,
// all through one shared multiplier. Depends on hpng_pkg.
`default_nettype none
module hpng_lane import hpng_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_op_t                   op,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [GAIN_W-1:0]          gain,
	input  logic [COEF_W-1:0]          hpc,
	input  logic [GAIN_W-1:0]          level,
	output logic signed [HP_W-1:0]     hp,
	output logic signed [SAMPLE_W-1:0] result
);

	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] gl_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [HP_W-1:0]     hp_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic signed [HP_W+1:0]   diff;
	logic signed [HP_W+2:0]   mul_a;
	logic signed [GAIN_W:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [RND_W-1:0]  rnd;

	assign diff = (HP_W+2)'(hp_q) + (HP_W+2)'(gl_q) - (HP_W+2)'(prev_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			LN_GAIN_MUL: begin
				mul_a = (HP_W+3)'(sample);
				mul_b = signed'({1'b0, gain});
			end
			LN_HP_MUL: begin
				mul_a = (HP_W+3)'(diff);
				mul_b = signed'({2'b00, hpc});
			end
			LN_OUT_MUL: begin
				mul_a = (HP_W+3)'(gl_q);
				mul_b = signed'({1'b0, level});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign rnd  = rnd_sh(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q   <= '0;
			prev_q <= '0;
		end else if (op == LN_HP_SAT) begin
			hp_q   <= sat_hp(rnd);
			prev_q <= gl_q;
		end
	end

	always_ff @(posedge clk) begin
		case (op) inside
			LN_GAIN_MUL, LN_HP_MUL, LN_OUT_MUL: prod_q <= prod;
			LN_GAIN_SAT: gl_q <= sat_smp(rnd);
			LN_OUT_SAT: out_q <= sat_smp(rnd);
			default: ;
		endcase
	end

	assign hp     = hp_q;
	assign result = out_q;

endmodule
`default_nettype wire

/* sv/hpng_merge.sv */
// Merging stage: noise level from both lanes, serial divide against the
// threshold, target gain and the gain smoother. Depends on hpng_pkg.
`default_nettype none
module hpng_merge import hpng_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  merge_op_t              op,
	input  logic signed [HP_W-1:0] hp_l,
	input  logic signed [HP_W-1:0] hp_r,
	input  logic [THR_W-1:0]       thr,
	input  logic [GAIN_W-1:0]      red,
	input  logic [COEF_W-1:0]      smooth,
	output logic [GAIN_W-1:0]      gain,
	output logic                   div_done
);

	logic [GAIN_W-1:0]    sg_q;
	logic                 gate_q;
	logic [THR_W-1:0]     rem_q;
	logic [FRAC-1:0]      quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     acc_q;
	logic [GAIN_W-1:0]    tgt_q;

	logic [HP_W-1:0]  abs_l;
	logic [HP_W-1:0]  abs_r;
	logic [HP_W:0]    sum;
	logic [HP_W-1:0]  noise;
	logic [THR_W:0]   rem2;
	logic             take;
	logic [ACC_W-1:0] acc_rnd;
	logic [ACC_W-FRAC-1:0] rnd;

	assign abs_l = hp_l[HP_W-1] ? HP_W'(-hp_l) : HP_W'(hp_l);
	assign abs_r = hp_r[HP_W-1] ? HP_W'(-hp_r) : HP_W'(hp_r);
	assign sum   = {1'b0, abs_l} + {1'b0, abs_r};
	assign noise = sum[HP_W:1];

	// Restoring division: the remainder stays below the threshold whenever the starting noise level is below it.
	assign rem2 = {rem_q, 1'b0};
	assign take = rem2 >= {1'b0, thr};

	assign acc_rnd = acc_q + ACC_W'(1 << (FRAC - 1));
	assign rnd     = acc_rnd[ACC_W-1:FRAC];

	assign div_done = (op == MG_DIV) && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sg_q <= UNITY;
		end else if (op == MG_SM_END) begin
			sg_q <= (rnd > (ACC_W-FRAC)'(UNITY)) ? UNITY : rnd[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			MG_NOISE: begin
				gate_q <= (thr != '0) && (noise < HP_W'(thr));
				rem_q  <= noise[THR_W-1:0];
				quo_q  <= '0;
				cnt_q  <= '0;
			end
			MG_DIV: begin
				rem_q <= take ? THR_W'(rem2 - {1'b0, thr}) : rem2[THR_W-1:0];
				quo_q <= {quo_q[FRAC-2:0], take};
				cnt_q <= cnt_q + 1'b1;
			end
			MG_TGT_MUL: acc_q <= ACC_W'(red) * ACC_W'(UNITY - {1'b0, quo_q});
			MG_TGT: tgt_q <= gate_q ? (UNITY - rnd[GAIN_W-1:0]) : UNITY;
			MG_SM_A: acc_q <= ACC_W'(sg_q) * ACC_W'(smooth);
			MG_SM_B: acc_q <= acc_q + ACC_W'(tgt_q) * ACC_W'(UNITY - {1'b0, smooth});
			default: ;
		endcase
	end

	assign gain = sg_q;

endmodule
`default_nettype wire
